// ===== hdl/srms_pkg.sv =====
// Shared types and constants for the stereo RMS level meter.
package srms_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 15;
    localparam int Q15_W      = 15;
    localparam int FRAMES_W   = 11;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = 40;
    localparam int ROOT_W     = 20;
    localparam int PROD_W     = ROOT_W + Q15_W;
    localparam int ALU_W      = 42;
    localparam int ITER_W     = 6;
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = SUM_W / 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 2'd2;

    localparam logic [FRAMES_W-1:0] RST_BLOCK_FRAMES = 11'd256;
    localparam logic [Q15_W-1:0]    RST_DECAY        = 15'd30474;
    localparam logic [Q15_W-1:0]    RST_GAIN         = 15'd2294;
    localparam logic [Q15_W-1:0]    LEVEL_MAX        = 15'h7fff;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic [Q15_W-1:0] block_rms;
        logic [Q15_W-1:0] smoothed_level;
    } t_out_item;

    typedef struct packed {
        logic             op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] value;
        logic             borrow;
    } t_alu_res;

endpackage

// ===== hdl/srms_alu.sv =====
// Shared add / compare-subtract unit.
module srms_alu (
    input  srms_pkg::t_alu_req i_req,
    output srms_pkg::t_alu_res o_res
);

    logic [srms_pkg::ALU_W:0] w_full;

    always_comb begin
        if (i_req.op == srms_pkg::ALU_SUB) begin
            w_full = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            w_full = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
    end

    // top bit is carry on add, borrow (a < b) on subtract
    assign o_res.value  = w_full[srms_pkg::ALU_W-1:0];
    assign o_res.borrow = w_full[srms_pkg::ALU_W];

endmodule

// ===== hdl/srms_mul.sv =====
// Shared registered multiplier, 20 x 15 bits unsigned.
module srms_mul (
    input  logic                         i_clk,
    input  logic [srms_pkg::ROOT_W-1:0]  i_a,
    input  logic [srms_pkg::Q15_W-1:0]   i_b,
    output logic [srms_pkg::PROD_W-1:0]  o_prod
);

    logic [srms_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= srms_pkg::PROD_W'(i_a) * srms_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/stereo_rms_level_meter.sv =====
// Stereo RMS level meter: sequencer around a shared multiplier and add/subtract unit.
// A frame that does not close a block steps through accept, square left, square right and
//   accumulate; the next frame is accepted only once the meter is back in idle.
// A block-closing frame adds 40 divide, 20 root and 3 smoothing steps before the result
//   is valid; the last step waits while an older result is still stalled at the output.
// Sync reset clears sum, count, smoothed level, output valid; config to 256/30474/2294.
module stereo_rms_level_meter #(
    parameter int MAX_BLOCK_FRAMES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  srms_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output srms_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [srms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srms_pkg::CFG_W-1:0]      i_cfg_data
);

    // frame counter wide enough to hold the largest block length
    localparam int FCW = $clog2(MAX_BLOCK_FRAMES + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQL  = 4'd1;  // square left
    localparam logic [3:0] ST_SQR  = 4'd2;  // square right, add left
    localparam logic [3:0] ST_ACC  = 4'd3;  // add right, block end check
    localparam logic [3:0] ST_DIV  = 4'd4;  // sum / (2 * frames), one bit per cycle
    localparam logic [3:0] ST_SQRT = 4'd5;  // floor root, one bit per cycle
    localparam logic [3:0] ST_MX1  = 4'd6;  // smoothed * decay
    localparam logic [3:0] ST_MX2  = 4'd7;  // rms * gain
    localparam logic [3:0] ST_MX3  = 4'd8;  // add, scale, saturate, emit

    // halved sample magnitude: arithmetic shift right, then absolute value
    function automatic logic [srms_pkg::MAG_W-1:0] half_mag(
        input logic signed [srms_pkg::SAMPLE_W-1:0] s
    );
        logic signed [srms_pkg::SAMPLE_W-1:0] h;
        h = s >>> 1;
        half_mag = h[srms_pkg::SAMPLE_W-1] ? srms_pkg::MAG_W'(-h) : h[srms_pkg::MAG_W-1:0];
    endfunction

    logic [3:0]                      r_state, n_state;
    logic [srms_pkg::FRAMES_W-1:0]   r_block_frames;
    logic [srms_pkg::Q15_W-1:0]      r_decay, r_gain;
    logic [srms_pkg::SUM_W-1:0]      r_sum, n_sum;
    logic [FCW-1:0]                  r_frame_count, n_frame_count;
    logic [srms_pkg::Q15_W-1:0]      r_smoothed, n_smoothed;
    logic [srms_pkg::MAG_W-1:0]      r_mag_l, r_mag_r;
    logic [srms_pkg::ALU_W-1:0]      r_rem, n_rem;
    logic [srms_pkg::ROOT_W-1:0]     r_root, n_root;
    logic [srms_pkg::ITER_W-1:0]     r_iter, n_iter;
    logic                            r_out_valid, n_out_valid;
    srms_pkg::t_out_item             r_out, n_out;

    logic [FCW-1:0]                  w_frames;
    logic [FCW-1:0]                  w_count_next;
    logic [FCW:0]                    w_divisor;
    logic [srms_pkg::ALU_W-1:0]      w_div_trial, w_sq_rem;
    logic [srms_pkg::ROOT_W-1:0]     w_mul_a;
    logic [srms_pkg::Q15_W-1:0]      w_mul_b;
    logic [srms_pkg::PROD_W-1:0]     w_prod;
    logic [srms_pkg::PROD_W-srms_pkg::Q15_W:0] w_mix;
    logic [srms_pkg::Q15_W-1:0]      w_mix_sat;
    logic                            w_accept, w_out_free;
    srms_pkg::t_alu_req              w_alu_req;
    srms_pkg::t_alu_res              w_alu_res;

    srms_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    srms_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // effective block length: zero acts as one, clamp at the maximum
    always_comb begin
        if (r_block_frames == '0) begin
            w_frames = FCW'(1);
        end else if (32'(r_block_frames) > 32'(MAX_BLOCK_FRAMES)) begin
            w_frames = FCW'(MAX_BLOCK_FRAMES);
        end else begin
            w_frames = FCW'(r_block_frames);
        end
    end

    assign w_count_next = r_frame_count + FCW'(1);
    assign w_divisor    = {w_frames, 1'b0};
    assign w_div_trial  = {r_rem[srms_pkg::ALU_W-2:0], r_sum[srms_pkg::SUM_W-1]};
    assign w_sq_rem     = {r_rem[srms_pkg::ALU_W-3:0],
                           r_sum[srms_pkg::SUM_W-1:srms_pkg::SUM_W-2]};

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !(r_out_valid && i_out_stall);

    // scaled mix = sum >> 15, saturated to 15 bits
    assign w_mix     = w_alu_res.value[srms_pkg::PROD_W:srms_pkg::Q15_W];
    assign w_mix_sat = (w_mix > (srms_pkg::PROD_W-srms_pkg::Q15_W+1)'(srms_pkg::LEVEL_MAX))
                       ? srms_pkg::LEVEL_MAX : w_mix[srms_pkg::Q15_W-1:0];

    // operand steering for the shared units
    always_comb begin
        w_alu_req = '{op: srms_pkg::ALU_ADD, a: '0, b: '0};
        w_mul_a   = '0;
        w_mul_b   = '0;
        unique case (r_state)
            ST_SQL: begin
                w_mul_a = srms_pkg::ROOT_W'(r_mag_l);
                w_mul_b = r_mag_l;
            end
            ST_SQR: begin
                w_mul_a   = srms_pkg::ROOT_W'(r_mag_r);
                w_mul_b   = r_mag_r;
                w_alu_req = '{op: srms_pkg::ALU_ADD, a: srms_pkg::ALU_W'(r_sum),
                              b: srms_pkg::ALU_W'(w_prod)};
            end
            ST_ACC: begin
                w_alu_req = '{op: srms_pkg::ALU_ADD, a: srms_pkg::ALU_W'(r_sum),
                              b: srms_pkg::ALU_W'(w_prod)};
            end
            ST_DIV: begin
                w_alu_req = '{op: srms_pkg::ALU_SUB, a: w_div_trial,
                              b: srms_pkg::ALU_W'(w_divisor)};
            end
            ST_SQRT: begin
                w_alu_req = '{op: srms_pkg::ALU_SUB, a: w_sq_rem,
                              b: srms_pkg::ALU_W'({r_root, 2'b01})};
            end
            ST_MX1: begin
                w_mul_a = srms_pkg::ROOT_W'(r_smoothed);
                w_mul_b = r_decay;
            end
            ST_MX2, ST_MX3: begin
                // MX3 keeps the operands so the product holds while the output stalls
                w_mul_a = r_root;
                w_mul_b = r_gain;
                if (r_state == ST_MX3) begin
                    w_alu_req = '{op: srms_pkg::ALU_ADD, a: r_rem,
                                  b: srms_pkg::ALU_W'(w_prod)};
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_sum         = r_sum;
        n_frame_count = r_frame_count;
        n_smoothed    = r_smoothed;
        n_rem         = r_rem;
        n_root        = r_root;
        n_iter        = r_iter;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SQL;
                end
            end
            ST_SQL: begin
                n_state = ST_SQR;
            end
            ST_SQR: begin
                n_sum   = w_alu_res.value[srms_pkg::SUM_W-1:0];
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_sum = w_alu_res.value[srms_pkg::SUM_W-1:0];
                if (w_count_next >= w_frames) begin
                    n_frame_count = '0;
                    n_rem         = '0;
                    n_iter        = '0;
                    n_state       = ST_DIV;
                end else begin
                    n_frame_count = w_count_next;
                    n_state       = ST_IDLE;
                end
            end
            ST_DIV: begin
                // restoring divide: quotient bits shift into the sum register
                n_rem = w_alu_res.borrow ? w_div_trial : w_alu_res.value;
                n_sum = {r_sum[srms_pkg::SUM_W-2:0], !w_alu_res.borrow};
                if (r_iter == srms_pkg::ITER_W'(srms_pkg::DIV_STEPS - 1)) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_iter  = '0;
                    n_state = ST_SQRT;
                end else begin
                    n_iter = r_iter + srms_pkg::ITER_W'(1);
                end
            end
            ST_SQRT: begin
                // two radicand bits per step, one root bit out
                n_rem  = w_alu_res.borrow ? w_sq_rem : w_alu_res.value;
                n_root = {r_root[srms_pkg::ROOT_W-2:0], !w_alu_res.borrow};
                n_sum  = {r_sum[srms_pkg::SUM_W-3:0], 2'b00};
                if (r_iter == srms_pkg::ITER_W'(srms_pkg::SQRT_STEPS - 1)) begin
                    n_state = ST_MX1;
                end else begin
                    n_iter = r_iter + srms_pkg::ITER_W'(1);
                end
            end
            ST_MX1: begin
                n_state = ST_MX2;
            end
            ST_MX2: begin
                n_rem   = srms_pkg::ALU_W'(w_prod);
                n_state = ST_MX3;
            end
            ST_MX3: begin
                if (w_out_free) begin
                    n_smoothed  = w_mix_sat;
                    n_out       = '{block_rms: r_root[srms_pkg::Q15_W-1:0],
                                    smoothed_level: w_mix_sat};
                    n_out_valid = 1'b1;
                    n_sum       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_sum          <= '0;
            r_frame_count  <= '0;
            r_smoothed     <= '0;
            r_out_valid    <= 1'b0;
            r_block_frames <= srms_pkg::RST_BLOCK_FRAMES;
            r_decay        <= srms_pkg::RST_DECAY;
            r_gain         <= srms_pkg::RST_GAIN;
        end else begin
            r_state       <= n_state;
            r_sum         <= n_sum;
            r_frame_count <= n_frame_count;
            r_smoothed    <= n_smoothed;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    srms_pkg::CFG_BLOCK_FRAMES:
                        r_block_frames <= i_cfg_data[srms_pkg::FRAMES_W-1:0];
                    srms_pkg::CFG_DECAY: r_decay <= i_cfg_data;
                    srms_pkg::CFG_GAIN:  r_gain  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_iter <= n_iter;
        r_out  <= n_out;
        if (w_accept) begin
            r_mag_l <= half_mag(i_in_data.left_sample);
            r_mag_r <= half_mag(i_in_data.right_sample);
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SQL))
        else $error("accepted transaction did not start the square step");

    a_result_from_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_MX3))
        else $error("result appeared outside the smoothing step");

    a_block_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_frame_count == '0) |-> (r_sum == '0))
        else $error("accumulator not clear at block start");
`endif

endmodule
